// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants for the UTF-8 to UTF-32 decoder
// Holds the decode state record, the step result record and the byte masks.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    // Byte masks and field widths
    localparam logic [7:0] C_LEAD_TOP_BIT  = 8'h80;  // set on lead and continuation bytes
    localparam logic [7:0] C_PAYLOAD_MASK  = 8'h3F;  // payload of a continuation byte
    localparam int unsigned C_CONT_BITS    = 6;      // payload bits per continuation byte
    localparam int unsigned C_RUN_BITS     = 7;      // bits scanned for the run of ones
    localparam logic [2:0] C_ASCII_KEEP    = 3'd7;   // payload bits of a plain ASCII byte
    localparam logic [2:0] C_MAX_LEAD_KEEP = 3'd6;   // payload bits of a lead with no run

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [31:0] partial;     // payload gathered so far
        logic [2:0]  bytes_left;  // continuation bytes still expected
    } t_state;

    // Result of one decode step
    typedef struct packed {
        logic        emit;        // a code point is complete (or flushed)
        logic [31:0] code_point;
    } t_step_out;

endpackage

// ===== hw/rtl/utf8d_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_if: streaming channels of the UTF-8 to UTF-32 decoder
// Byte channel in, code point channel out, both valid/ready.
// ----------------------------------------------------------------------------

// Byte channel: one raw UTF-8 byte per transaction
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// Code point channel: one decoded character per transaction
interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

// ===== hw/rtl/utf8d_step.sv =====
// ----------------------------------------------------------------------------
// utf8d_step: one decode step
// Folds one byte into the decoder state and flags a finished code point.
// ----------------------------------------------------------------------------
module utf8d_step (
    input  utf8d_pkg::t_state    i_state,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_last_byte,
    output utf8d_pkg::t_state    o_state,
    output utf8d_pkg::t_step_out o_result
);

    logic [2:0]  run_len;
    logic        run_on;
    logic [2:0]  keep;
    logic [7:0]  keep_mask;
    logic [31:0] gathered;
    logic [2:0]  left_after;

    // Length of the run of ones below the top bit of a lead byte
    always_comb begin
        run_len = 3'd0;
        run_on  = 1'b1;
        for (int k = utf8d_pkg::C_RUN_BITS - 1; k >= 0; k--) begin
            if (run_on && i_in_byte[k]) begin
                run_len = run_len + 3'd1;
            end else begin
                run_on = 1'b0;
            end
        end
    end

    // Payload bits kept from a lead byte; long runs keep none
    always_comb begin
        if ((i_in_byte & utf8d_pkg::C_LEAD_TOP_BIT) == 8'h00) begin
            keep = utf8d_pkg::C_ASCII_KEEP;
        end else if (run_len >= utf8d_pkg::C_MAX_LEAD_KEEP) begin
            keep = 3'd0;
        end else begin
            keep = utf8d_pkg::C_MAX_LEAD_KEEP - run_len;
        end
        keep_mask = (8'd1 << keep) - 8'd1;
    end

    // Lead byte starts a value, continuation shifts in six bits
    always_comb begin
        if (i_state.bytes_left == 3'd0) begin
            gathered   = {24'd0, i_in_byte & keep_mask};
            left_after = ((i_in_byte & utf8d_pkg::C_LEAD_TOP_BIT) == 8'h00) ? 3'd0 : run_len;
        end else begin
            gathered   = {i_state.partial[31-utf8d_pkg::C_CONT_BITS:0],
                          i_in_byte[utf8d_pkg::C_CONT_BITS-1:0]};
            left_after = i_state.bytes_left - 3'd1;
        end
    end

    // Emit on completion or end of string; end of string clears the state
    always_comb begin
        o_result.emit       = (left_after == 3'd0) || i_last_byte;
        o_result.code_point = gathered;
        o_state.partial     = i_last_byte ? 32'd0 : gathered;
        o_state.bytes_left  = o_result.emit ? 3'd0 : left_after;
    end

endmodule

// ===== hw/rtl/utf8_to_utf32_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder: streaming UTF-8 to UTF-32 decoder
// Input register, one decode step, result register.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one UTF-8 byte per transaction with last_byte marking the
//   end of a string. o_cp carries one 32-bit code point per character; a
//   character cut short by last_byte is flushed with the bits gathered so far.
//   Bytes are not validated; a stray continuation byte decodes on its own.
//   Throughput: one byte per cycle, set by the single decode step between
//   the input register and the result register, unless a byte that emits
//   waits behind a held result. A code point's final byte is accepted into
//   the input register, then decoded into the result register, which drives
//   o_cp; a held result can stall that move.
//   Reset (i_rst_n low, synchronous) empties both registers and clears the
//   decode state, so the next byte starts a new string.
//   When the receiver holds o_cp.ready low, the result register keeps its
//   code point, the input register still fills, and bytes that complete no
//   character keep flowing; i_byte.ready drops only once a byte that would
//   emit waits behind the held result.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    utf8d_byte_if.sink          i_byte,
    utf8d_cp_if.source          o_cp
);

    // Input register
    logic                 r_s1_valid;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;

    // Decode state and result register
    utf8d_pkg::t_state    r_state;
    utf8d_pkg::t_state    n_state;
    utf8d_pkg::t_step_out step_res;
    logic                 r_out_valid;
    logic [31:0]          r_out_cp;

    logic                 out_free;
    logic                 s1_take;

    utf8d_step u_step (
        .i_state     (r_state),
        .i_in_byte   (r_s1_byte),
        .i_last_byte (r_s1_last),
        .o_state     (n_state),
        .o_result    (step_res)
    );

    // Flow control: a byte moves on unless it emits into a held result
    assign out_free     = !r_out_valid || o_cp.ready;
    assign s1_take      = r_s1_valid && (!step_res.emit || out_free);
    assign i_byte.ready = !r_s1_valid || s1_take;

    assign o_cp.valid      = r_out_valid;
    assign o_cp.code_point = r_out_cp;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_s1_valid <= i_byte.valid;
        end
        if (i_byte.ready && i_byte.valid) begin
            r_s1_byte <= i_byte.in_byte;
            r_s1_last <= i_byte.last_byte;
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_take) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_take && step_res.emit;
        end
        if (out_free && s1_take && step_res.emit) begin
            r_out_cp <= step_res.code_point;
        end
    end

`ifndef NO_ASSERTIONS
    // End of string leaves a clean state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_take && r_s1_last |=> (r_state.bytes_left == 3'd0) && (r_state.partial == 32'd0))
        else $error("state not cleared after last byte");

    // A byte that emits nothing leaves continuation bytes pending
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_take && !step_res.emit |=> r_state.bytes_left != 3'd0)
        else $error("silent byte left no pending continuation");

    // A new result only follows a decoded byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_take && step_res.emit))
        else $error("result appeared without a decoded byte");
`endif

endmodule

// ===== test/utf8_to_utf32_decoder_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_scoreboard: code point predictor and checker
// Watches the byte and code point channels, decodes every accepted byte
// into the expected code points and compares each output transaction with
// the oldest expected one.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_scoreboard (
    input  logic   i_clk,
    input  logic   i_rst_n,
    utf8d_byte_if  byte_ch,
    utf8d_cp_if    cp_ch,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int MAX_REPORTS = 10;
    localparam int EXP_DEPTH   = 64;

    // Decode state of the prediction
    logic [31:0] gathered_bits;
    logic [2:0]  cont_left;
    logic [31:0] expected_cps [EXP_DEPTH];
    int          exp_head;
    int          exp_count;
    int          fail_count;

    // Length of the run of ones below the top bit, scanned from bit 6 down
    function automatic logic [2:0] lead_run(input logic [7:0] b);
        logic [2:0] n;
        n = '0;
        for (int i = 6; i >= 0; i--) begin
            if (b[i] && n == 3'(6 - i))
                n++;
        end
        return n;
    endfunction

    // Note a failure, with details for the first few only
    task automatic report_fail(input string what, input logic [31:0] exp_cp,
                               input logic [31:0] got_cp);
        if (fail_count < MAX_REPORTS)
            $display("%0t ERROR: %s: expected 0x%08h, got 0x%08h",
                     $realtime, what, exp_cp, got_cp);
        fail_count++;
    endtask

    // Append one expected code point to the ring
    task automatic add_expected(input logic [31:0] cp);
        if (exp_count == EXP_DEPTH) begin
            report_fail("expected code point overflow", cp, 32'h0);
        end else begin
            expected_cps[(exp_head + exp_count) % EXP_DEPTH] = cp;
            exp_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [31:0] exp_cp;
        logic [2:0]  run;
        int unsigned keep;
        logic        done;
        if (!i_rst_n) begin
            gathered_bits = '0;
            cont_left     = '0;
            exp_head      = 0;
            exp_count     = 0;
            fail_count    = 0;
        end else begin
            // Output side: compare against the oldest expected code point
            if (cp_ch.valid && cp_ch.ready) begin
                if (exp_count == 0) begin
                    report_fail("code point with none expected", 32'h0, cp_ch.code_point);
                end else begin
                    exp_cp    = expected_cps[exp_head];
                    exp_head  = (exp_head + 1) % EXP_DEPTH;
                    exp_count--;
                    if (cp_ch.code_point !== exp_cp)
                        report_fail("code point mismatch", exp_cp, cp_ch.code_point);
                end
            end

            // Input side: advance the decode by one byte
            if (byte_ch.valid && byte_ch.ready) begin
                if (cont_left == 0) begin
                    if (byte_ch.in_byte[7]) begin
                        run  = lead_run(byte_ch.in_byte);
                        keep = (run >= 6) ? 0 : 6 - run;
                    end else begin
                        run  = '0;
                        keep = 7;
                    end
                    gathered_bits = {24'h0, byte_ch.in_byte} & ((32'd1 << keep) - 32'd1);
                    cont_left     = run;
                end else begin
                    // top bits of a continuation byte are ignored
                    gathered_bits = (gathered_bits << 6)
                                  | {24'h0, byte_ch.in_byte & utf8d_pkg::C_PAYLOAD_MASK};
                    cont_left     = cont_left - 3'd1;
                end
                done = (cont_left == 0);

                // complete character, or flush at end of string
                if (done || byte_ch.last_byte) begin
                    add_expected(gathered_bits);
                    if (byte_ch.last_byte)
                        gathered_bits = '0;
                    cont_left = '0;
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = exp_count;
    end

endmodule

// ===== test/utf8_to_utf32_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_tb: stream test of the UTF-8 to UTF-32 decoder
// Sends directed byte sequences (ASCII, stray continuation bytes, 2 to 4
// byte characters, 0xFF/0xFE leads, a cut-short string end) and then random
// strings of mostly well-formed characters with noise mixed in, under random
// idling on both channels and one long receiver hold-off. The scoreboard
// predicts and checks every code point.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_tb;

    localparam int TOTAL_BYTES   = 1300;
    localparam int QUIET_BYTES   = 200;   // tail of the run with no idling
    localparam int HOLD_AT_BYTE  = 400;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 10;

    // Directed bytes; bit 8 marks the end of a string
    localparam logic [8:0] DIRECTED [24] = '{
        9'h000, 9'h07F,                                  // ASCII extremes
        9'h080, 9'h0BF,                                  // stray continuation bytes
        9'h0C2, 9'h0A9,                                  // two-byte character
        9'h0E2, 9'h082, 9'h0AC,                          // three-byte character
        9'h0F0, 9'h09F, 9'h098, 9'h080,                  // four-byte character
        9'h0FF, 9'h0FF, 9'h03F, 9'h0C0, 9'h000, 9'h0BF,  // 0xFF lead, overflow,
        9'h080, 9'h0FF,                                  //   odd continuation tops
        9'h0FE, 9'h0BF, 9'h1BF                           // 0xFE lead cut short
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   byte_count;
    logic idle_on;
    logic hold_req;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;

    always #1 i_clk = ~i_clk;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_to_utf32_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_cp    (cp_ch)
    );

    utf8_to_utf32_decoder_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_ch      (byte_ch),
        .cp_ch        (cp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one byte, with an optional idle burst first; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.in_byte   <= b;
        byte_ch.last_byte <= last;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        byte_count++;
    endtask

    // One string of random characters, mostly well formed
    task automatic send_random_string();
        int unsigned n_chars;
        int unsigned kind;
        int unsigned extra;
        int unsigned n_cont;
        logic        final_char;
        logic [7:0]  lead;
        logic [7:0]  cont;
        n_chars = $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++) begin
            final_char = (c == n_chars - 1);
            kind       = $urandom_range(0, 99);
            if (kind < 10) begin
                // noise: any byte, end flag at random
                send_byte(8'($urandom), $urandom_range(0, 15) == 0);
            end else if (kind < 15) begin
                send_byte(utf8d_pkg::C_LEAD_TOP_BIT
                          | (8'($urandom) & utf8d_pkg::C_PAYLOAD_MASK), final_char);
            end else if (kind < 50) begin
                send_byte(8'($urandom_range(0, 127)), final_char);
            end else begin
                extra  = (kind < 92) ? $urandom_range(1, 3) : $urandom_range(4, 7);
                lead   = (8'hFF << (7 - extra)) | (8'($urandom) & (8'hFF >> (extra + 2)));
                // sometimes the string ends inside this character
                n_cont = (final_char && $urandom_range(0, 4) == 0)
                       ? $urandom_range(0, extra - 1) : extra;
                send_byte(lead, final_char && n_cont == 0);
                for (int k = 0; k < n_cont; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        cont = 8'($urandom);
                    else
                        cont = utf8d_pkg::C_LEAD_TOP_BIT
                             | (8'($urandom) & utf8d_pkg::C_PAYLOAD_MASK);
                    send_byte(cont, final_char && k == n_cont - 1);
                end
            end
        end
    endtask

    // Receiver: random stall bursts plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            cp_ch.ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            cp_ch.ready <= 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else if (stall_left != 0) begin
            cp_ch.ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            cp_ch.ready <= 1'b0;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            cp_ch.ready <= 1'b1;
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.in_byte   = '0;
        byte_ch.last_byte = 1'b0;
        idle_on           = 1'b1;
        hold_req          = 1'b0;
        byte_count        = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        while (byte_count < TOTAL_BYTES) begin
            if (byte_count >= HOLD_AT_BYTE)
                hold_req <= 1'b1;
            if (byte_count >= TOTAL_BYTES - QUIET_BYTES)
                idle_on <= 1'b0;
            send_random_string();
        end
        byte_ch.valid <= 1'b0;

        // drain outstanding code points, then let the pipeline settle
        for (int i = 0; i < DRAIN_LIMIT && pending != 0; i++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending != 0)
            $display("ERROR: %0d expected code points never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
